### sv/assert_macros.svh
// Assertion macros shared by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed: a |-> b");

// Next-cycle implication, off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed: a |=> b");

`endif

### sv/sfl_pkg.sv
// Package: widths, tap count and coefficient table of the symmetric low-pass filter.
package sfl_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 13;
    localparam int PROD_W   = SAMPLE_W + COEF_W + 1;
    localparam int ACC_W    = 32;
    localparam int SHIFT    = 15;
    localparam int NUM_TAPS = 23;
    localparam int NUM_COEF = 12;
    localparam int CENTER   = NUM_COEF - 1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic [NUM_COEF-1:0][ACC_W-1:0] prod_vec_t;

    function automatic logic [COEF_W-1:0] coef(input int k);
        logic [COEF_W-1:0] c;
        c = '0;
        case (k)
            0:       c = 13'd172;
            1:       c = 13'd321;
            2:       c = 13'd579;
            3:       c = 13'd927;
            4:       c = 13'd1360;
            5:       c = 13'd1858;
            6:       c = 13'd2390;
            7:       c = 13'd2916;
            8:       c = 13'd3391;
            9:       c = 13'd3768;
            10:      c = 13'd4012;
            11:      c = 13'd4096;
            default: c = '0;
        endcase
        return c;
    endfunction

    // Tap position to coefficient index; the taps mirror about the center.
    function automatic int tap_coef(input int tap);
        return (tap <= CENTER) ? tap : (NUM_TAPS - 1 - tap);
    endfunction

endpackage

### sv/sfl_products.sv
// Module: the twelve coefficient products of the incoming sample.
module sfl_products (
    input  logic signed [sfl_pkg::SAMPLE_W-1:0] sample,
    output sfl_pkg::prod_vec_t                  products
);

    localparam int PW = sfl_pkg::PROD_W;

    for (genvar k = 0; k < sfl_pkg::NUM_COEF; k++) begin : g_prod
        logic signed [PW-1:0] p;
        assign p = PW'(sample) * PW'($signed({1'b0, sfl_pkg::coef(k)}));
        assign products[k] = {{(sfl_pkg::ACC_W-PW){p[PW-1]}}, p};
    end

endmodule

### sv/sfl_cell.sv
// Module: one partial-sum cell of the transposed filter chain.
module sfl_cell (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     advance,
    input  logic [sfl_pkg::ACC_W-1:0] partial_in,
    input  logic [sfl_pkg::ACC_W-1:0] product,
    output logic [sfl_pkg::ACC_W-1:0] partial_out
);

    logic [sfl_pkg::ACC_W-1:0] partial_reg;
    logic [sfl_pkg::ACC_W-1:0] partial_next;

    assign partial_next = partial_in + product;
    assign partial_out  = partial_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg <= '0;
        end else if (advance) begin
            partial_reg <= partial_next;
        end
    end

endmodule

### sv/symmetric_fir_lowpass.sv
// Top level: 23-tap symmetric low-pass FIR with valid/ready channels.
//
// Input channel s_valid/s_ready/s_sample_in carries one signed 16-bit sample
// per request; output channel m_valid/m_ready/m_filtered_out carries one
// signed 16-bit result per sample, in order.
// The filter is built in transposed form: a row of 22 partial-sum cells,
// each adding its coefficient product of the new sample to the partial sum
// handed on by its neighbor. The cells advance once per accepted request.
// The result is in the output register in the cycle after the sample
// is accepted. The filter takes one sample per cycle while s_ready is high,
// each cell doing its product-and-add ahead of its register.
// The result is bits 30..15 of the 32-bit sum (floor shift, wrapping).
// Reset (aresetn low, synchronous) clears every cell, which matches an
// all-zero sample history, and drops any pending result.
// While the receiver stalls, the pending result holds and s_ready is low;
// s_ready is high whenever the output register is empty or being drained.
`include "assert_macros.svh"

module symmetric_fir_lowpass (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [sfl_pkg::SAMPLE_W-1:0] s_sample_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [sfl_pkg::SAMPLE_W-1:0] m_filtered_out
);

    localparam int NCELL = sfl_pkg::NUM_TAPS - 1;
    localparam int AW    = sfl_pkg::ACC_W;
    localparam int SW    = sfl_pkg::SAMPLE_W;

    logic                   accept;
    sfl_pkg::prod_vec_t     products;
    logic [NCELL:0][AW-1:0] chain;
    logic [AW-1:0]          sum;

    logic          valid_reg;
    logic          valid_next;
    logic [SW-1:0] out_reg;

    assign s_ready = !valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    sfl_products u_products (
        .sample   (s_sample_in),
        .products (products)
    );

    // The end of the chain feeds zero into the oldest cell.
    assign chain[NCELL] = '0;

    for (genvar j = 0; j < NCELL; j++) begin : g_cell
        localparam int CI = sfl_pkg::tap_coef(j + 1);
        sfl_cell u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .advance     (accept),
            .partial_in  (chain[j+1]),
            .product     (products[CI]),
            .partial_out (chain[j])
        );
    end

    assign sum = chain[0] + products[sfl_pkg::tap_coef(0)];

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= sum[sfl_pkg::SHIFT+SW-1:sfl_pkg::SHIFT];
        end
    end

    assign m_valid        = valid_reg;
    assign m_filtered_out = $signed(out_reg);

    `ASSERT_NEXT(a_accept_gives_result, aclk, aresetn, accept, m_valid)
    `ASSERT_IMPL(a_stall_blocks_input, aclk, aresetn, m_valid && !m_ready, !s_ready)
    `ASSERT_NEXT(a_stall_holds_result, aclk, aresetn, m_valid && !m_ready,
                 m_valid && $stable(m_filtered_out))
    `ASSERT_NEXT(a_reset_empties, aclk, 1'b1, !aresetn, !m_valid)

endmodule
